// ===== rtl/shell_item_uri_record_validator_macros.svh =====
// assertion macros for the uri shell-item record validator
// expects clk and rst_n in the scope of use; no other dependencies
`ifndef SHELL_ITEM_URI_RECORD_VALIDATOR_MACROS_SVH
`define SHELL_ITEM_URI_RECORD_VALIDATOR_MACROS_SVH

// same-cycle implication
`define SIURV_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SIURV_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/siurv_pkg.sv =====
// shared widths, constants and codes for the uri shell-item record validator
// no dependencies
`default_nettype none

package siurv_pkg;

    localparam int LENGTH_BITS_DEF = 16;

    localparam int DATA_W    = 8;
    localparam int REC_LEN_W = 16;
    localparam int STATUS_W  = 2;
    localparam int FIELD_W   = 16;

    localparam logic [7:0] CLASS_URI = 8'h61;
    localparam int FLAG_WIDE_BIT     = 7;
    localparam int FIXED_BLOCK       = 36;
    localparam int MIN_RECORD        = 6;
    localparam int POS_CLASS         = 2;
    localparam int POS_FLAGS         = 3;
    localparam int POS_SIZE_LO       = 4;
    localparam int POS_SIZE_HI       = 5;
    localparam int LEN_PREFIX        = 4;

    localparam logic [1:0] PH_HEADER = 2'd0;
    localparam logic [1:0] PH_LENGTH = 2'd1;
    localparam logic [1:0] PH_URI    = 2'd2;
    localparam logic [1:0] PH_DONE   = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK          = 2'd0;
    localparam logic [STATUS_W-1:0] ST_UNSUPPORTED = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BOUNDS      = 2'd2;

endpackage

`default_nettype wire

// ===== rtl/siurv_in_if.sv =====
// record byte channel: valid, ready and one record byte with its length and last marker
// depends on siurv_pkg
`default_nettype none

interface siurv_in_if;
    import siurv_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [DATA_W-1:0]    data_byte;
    logic [REC_LEN_W-1:0] record_length;
    logic                 last_byte;

    modport source (output valid, output data_byte, output record_length,
                    output last_byte, input ready);
    modport sink   (input valid, input data_byte, input record_length,
                    input last_byte, output ready);
endinterface

`default_nettype wire

// ===== rtl/siurv_out_if.sv =====
// result channel: valid, ready and the status with uri offset, length and width
// depends on siurv_pkg
`default_nettype none

interface siurv_out_if;
    import siurv_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [FIELD_W-1:0]  uri_offset;
    logic [FIELD_W-1:0]  uri_length;
    logic                uri_wide;

    modport source (output valid, output status, output uri_offset,
                    output uri_length, output uri_wide, input ready);
    modport sink   (input valid, input status, input uri_offset,
                    input uri_length, input uri_wide, output ready);
endinterface

`default_nettype wire

// ===== rtl/shell_item_uri_record_validator.sv =====
// an item is registered in the input register when accepted and parsed from there into the
// parse state; a record's result is registered in the result register as its last byte advances
// throughput: one byte per cycle; while a result waits, bytes keep flowing up to the
// next record's last byte, which holds in the input register until the result is taken
// reset (rst_n low, asynchronous) clears all parse state and both valid flags at once
// depends on siurv_pkg, siurv_in_if, siurv_out_if and the assertion macro header
`default_nettype none

`include "shell_item_uri_record_validator_macros.svh"

module shell_item_uri_record_validator #(
    parameter int LENGTH_BITS = siurv_pkg::LENGTH_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    siurv_in_if.sink    rec,
    siurv_out_if.source res
);
    import siurv_pkg::*;

    localparam int PW = LENGTH_BITS;
    localparam int OW = ((LENGTH_BITS > REC_LEN_W) ? LENGTH_BITS : REC_LEN_W) + 1;

    // input register
    logic                 in_vld_reg;
    logic [DATA_W-1:0]    in_byte_reg;
    logic [REC_LEN_W-1:0] in_len_reg;
    logic                 in_last_reg;

    // parse state
    logic [PW-1:0]       pos_reg, pos_next;
    logic [1:0]          phase_reg, phase_next;
    logic                wide_reg, wide_next;
    logic [15:0]         rem_reg, rem_next;
    logic [PW-1:0]       nfo_reg, nfo_next;
    logic [23:0]         acc_reg, acc_next;
    logic [1:0]          sc_reg, sc_next;
    logic                prevz_reg, prevz_next;
    logic [PW-1:0]       ustart_reg, ustart_next;
    logic [PW-1:0]       usize_reg, usize_next;
    logic                tfound_reg, tfound_next;
    logic [STATUS_W-1:0] err_reg, err_next;

    // result register
    logic                out_vld_reg;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [FIELD_W-1:0]  uoff_reg, uoff_next;
    logic [FIELD_W-1:0]  ulen_reg, ulen_next;
    logic                uwide_reg, uwide_next;

    logic advance;

    // combinational helpers
    logic [PW+REC_LEN_W-1:0] len_ext;
    logic [PW-1:0]           len;
    logic [OW-1:0]           lenw;
    logic [DATA_W-1:0]       b;
    logic [PW-1:0]           p;
    logic                    take;
    logic [15:0]             s;
    logic [OW-1:0]           s6;
    logic [1:0]              k;
    logic [31:0]             full;
    logic [15:0]             rem_m4;
    logic [15:0]             rem_a;
    logic [OW-1:0]           off4;
    logic [OW-1:0]           off;
    logic [OW-1:0]           nfo_last;
    logic [PW-1:0]           du;
    logic [OW-1:0]           sz_w;
    logic [OW-1:0]           rest;

    assign advance   = in_vld_reg && (!in_last_reg || !out_vld_reg || res.ready);
    assign rec.ready = !in_vld_reg || advance;

    assign len_ext = {{PW{1'b0}}, in_len_reg};
    assign len     = len_ext[PW-1:0];
    assign lenw    = OW'(len);
    assign b       = in_byte_reg;
    assign p       = pos_reg;
    assign take    = (len >= PW'(MIN_RECORD)) && (p < len) && (phase_reg != PH_DONE);

    assign s        = {b, rem_reg[7:0]};
    assign s6       = OW'(s) + OW'(MIN_RECORD);
    assign k        = 2'(p - nfo_reg);
    assign full     = {b, acc_reg};
    assign rem_m4   = rem_reg - 16'(LEN_PREFIX);
    assign rem_a    = rem_m4 - full[15:0];
    assign off4     = OW'(nfo_reg) + OW'(LEN_PREFIX);
    assign off      = off4 + OW'(full[15:0]);
    assign nfo_last = OW'(nfo_reg) + OW'(rem_reg);
    assign du       = p - ustart_reg;

    always_comb
    begin
        pos_next    = pos_reg;
        phase_next  = phase_reg;
        wide_next   = wide_reg;
        rem_next    = rem_reg;
        nfo_next    = nfo_reg;
        acc_next    = acc_reg;
        sc_next     = sc_reg;
        prevz_next  = prevz_reg;
        ustart_next = ustart_reg;
        usize_next  = usize_reg;
        tfound_next = tfound_reg;
        err_next    = err_reg;
        status_next = ST_OK;
        uoff_next   = '0;
        ulen_next   = '0;
        uwide_next  = 1'b0;
        sz_w        = '0;
        rest        = '0;

        if (take)
        begin
            case (phase_reg)
                PH_HEADER:
                begin
                    if (p == PW'(POS_CLASS) && b != CLASS_URI)
                    begin
                        err_next   = ST_UNSUPPORTED;
                        phase_next = PH_DONE;
                    end
                    else if (p == PW'(POS_FLAGS))
                    begin
                        wide_next = b[FLAG_WIDE_BIT];
                    end
                    else if (p == PW'(POS_SIZE_LO))
                    begin
                        rem_next = {8'd0, b};
                    end
                    else if (p == PW'(POS_SIZE_HI))
                    begin
                        if (s6 > lenw)
                        begin
                            err_next   = ST_BOUNDS;
                            phase_next = PH_DONE;
                        end
                        else if (s >= 16'(FIXED_BLOCK))
                        begin
                            rem_next = s - 16'(FIXED_BLOCK);
                            nfo_next = PW'(MIN_RECORD + FIXED_BLOCK);
                            sc_next  = 2'd0;
                            if (OW'(MIN_RECORD + FIXED_BLOCK + LEN_PREFIX) >= lenw)
                            begin
                                err_next   = ST_BOUNDS;
                                phase_next = PH_DONE;
                            end
                            else
                            begin
                                acc_next   = '0;
                                phase_next = PH_LENGTH;
                            end
                        end
                        else
                        begin
                            rem_next    = '0;
                            nfo_next    = PW'(s6);
                            ustart_next = PW'(s6);
                            if (s6 >= lenw)
                            begin
                                err_next   = ST_BOUNDS;
                                phase_next = PH_DONE;
                            end
                            else
                            begin
                                tfound_next = 1'b0;
                                usize_next  = '0;
                                prevz_next  = 1'b1;
                                phase_next  = PH_URI;
                            end
                        end
                    end
                end
                PH_LENGTH:
                begin
                    if (p >= nfo_reg)
                    begin
                        if (k != 2'd3)
                        begin
                            case (k)
                                2'd0:    acc_next[7:0]   = b;
                                2'd1:    acc_next[15:8]  = b;
                                default: acc_next[23:16] = b;
                            endcase
                        end
                        else if (rem_reg < 16'(LEN_PREFIX) || full > {16'd0, rem_m4})
                        begin
                            err_next   = ST_BOUNDS;
                            phase_next = PH_DONE;
                        end
                        else if (off4 >= lenw)
                        begin
                            rem_next   = rem_m4;
                            err_next   = ST_BOUNDS;
                            phase_next = PH_DONE;
                        end
                        else
                        begin
                            sc_next = sc_reg + 2'd1;
                            if (sc_reg == 2'd2)
                            begin
                                nfo_next    = PW'(nfo_last);
                                ustart_next = PW'(nfo_last);
                                rem_next    = '0;
                                if (nfo_last >= lenw)
                                begin
                                    err_next   = ST_BOUNDS;
                                    phase_next = PH_DONE;
                                end
                                else
                                begin
                                    tfound_next = 1'b0;
                                    usize_next  = '0;
                                    prevz_next  = 1'b1;
                                    phase_next  = PH_URI;
                                end
                            end
                            else
                            begin
                                nfo_next = PW'(off);
                                rem_next = rem_a;
                                if (off + OW'(LEN_PREFIX) >= lenw)
                                begin
                                    err_next   = ST_BOUNDS;
                                    phase_next = PH_DONE;
                                end
                                else
                                begin
                                    acc_next   = '0;
                                    phase_next = PH_LENGTH;
                                end
                            end
                        end
                    end
                end
                PH_URI:
                begin
                    if (p >= ustart_reg)
                    begin
                        if (!tfound_reg && b == 8'd0 && (!wide_reg || (du[0] && prevz_reg)))
                        begin
                            tfound_next = 1'b1;
                            usize_next  = du + PW'(1);
                        end
                        prevz_next = (b == 8'd0);
                    end
                end
                default:
                begin
                end
            endcase
        end

        if (!in_last_reg)
        begin
            if (pos_reg != '1)
                pos_next = pos_reg + PW'(1);
        end
        else
        begin
            if (tfound_next)
                sz_w = OW'(usize_next);
            else if (wide_next)
                sz_w = (lenw - OW'(ustart_next)) & ~OW'(1);
            else
                sz_w = lenw - OW'(ustart_next);
            rest = lenw - (OW'(ustart_next) + sz_w);

            if (len < PW'(MIN_RECORD))
                status_next = ST_UNSUPPORTED;
            else if (OW'(p) + OW'(1) < lenw)
                status_next = ST_BOUNDS;
            else if (err_next != ST_OK)
                status_next = err_next;
            else if (phase_next != PH_URI)
                status_next = ST_BOUNDS;
            else if (rest inside {OW'(1), OW'(2)})
                status_next = ST_BOUNDS;
            else
                status_next = ST_OK;

            if (status_next == ST_OK)
            begin
                uoff_next  = FIELD_W'(ustart_next);
                ulen_next  = sz_w[FIELD_W-1:0];
                uwide_next = wide_next;
            end

            pos_next    = '0;
            phase_next  = PH_HEADER;
            wide_next   = 1'b0;
            rem_next    = '0;
            nfo_next    = '0;
            acc_next    = '0;
            sc_next     = '0;
            prevz_next  = 1'b1;
            ustart_next = '0;
            usize_next  = '0;
            tfound_next = 1'b0;
            err_next    = ST_OK;
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_vld_reg <= 1'b0;
        else if (rec.ready)
            in_vld_reg <= rec.valid;
    end

    always_ff @(posedge clk)
    begin
        if (rec.ready && rec.valid)
        begin
            in_byte_reg <= rec.data_byte;
            in_len_reg  <= rec.record_length;
            in_last_reg <= rec.last_byte;
        end
    end

    // parse state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            phase_reg  <= PH_HEADER;
            wide_reg   <= 1'b0;
            rem_reg    <= '0;
            nfo_reg    <= '0;
            acc_reg    <= '0;
            sc_reg     <= '0;
            prevz_reg  <= 1'b1;
            ustart_reg <= '0;
            usize_reg  <= '0;
            tfound_reg <= 1'b0;
            err_reg    <= ST_OK;
        end
        else if (advance)
        begin
            pos_reg    <= pos_next;
            phase_reg  <= phase_next;
            wide_reg   <= wide_next;
            rem_reg    <= rem_next;
            nfo_reg    <= nfo_next;
            acc_reg    <= acc_next;
            sc_reg     <= sc_next;
            prevz_reg  <= prevz_next;
            ustart_reg <= ustart_next;
            usize_reg  <= usize_next;
            tfound_reg <= tfound_next;
            err_reg    <= err_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (advance && in_last_reg)
            out_vld_reg <= 1'b1;
        else if (res.ready)
            out_vld_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_last_reg)
        begin
            status_reg <= status_next;
            uoff_reg   <= uoff_next;
            ulen_reg   <= ulen_next;
            uwide_reg  <= uwide_next;
        end
    end

    assign res.valid      = out_vld_reg;
    assign res.status     = status_reg;
    assign res.uri_offset = uoff_reg;
    assign res.uri_length = ulen_reg;
    assign res.uri_wide   = uwide_reg;

    `SIURV_ASSERT_NOW(a_fail_sets_error, (phase_reg == PH_DONE), (err_reg != ST_OK),
        "parse stopped without an error code")
    `SIURV_ASSERT_NOW(a_live_has_no_error, (phase_reg == PH_LENGTH || phase_reg == PH_URI),
        (err_reg == ST_OK), "error code set while parsing continues")
    `SIURV_ASSERT_NEXT(a_last_clears_state, (advance && in_last_reg),
        (pos_reg == '0 && phase_reg == PH_HEADER && err_reg == ST_OK),
        "record state not cleared after last item")
    `SIURV_ASSERT_NOW(a_fail_zero_fields, (out_vld_reg && status_reg != ST_OK),
        (uoff_reg == '0 && ulen_reg == '0 && !uwide_reg),
        "uri fields non-zero on a failed record")
    `SIURV_ASSERT_NOW(a_status_code, out_vld_reg,
        (status_reg == ST_OK || status_reg == ST_UNSUPPORTED || status_reg == ST_BOUNDS),
        "undefined status code on result")

endmodule

`default_nettype wire
